>>> hdl/qds_pkg.sv
package qds_pkg;

    // request store depth and core pool size
    localparam int MAX_REQUESTS = 256;
    localparam int MAX_CORES    = 16;

    typedef enum logic [1:0] {
        CMD_ARRIVAL = 2'd0,
        CMD_SLICE   = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_DISPATCH  = 3'd0,
        KIND_TIMEOUT   = 3'd1,
        KIND_DROPPED   = 3'd2,
        KIND_COMPLETED = 3'd3,
        KIND_PREEMPTED = 3'd4
    } t_kind;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_QLIMIT  = 3'd1;
    localparam logic [2:0] REG_CORES   = 3'd2;
    localparam logic [2:0] REG_QUANTUM = 3'd3;
    localparam logic [2:0] REG_SWITCH  = 3'd4;
    localparam logic [2:0] REG_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_WARMUP  = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] now;
        logic [7:0]  request_id;
        logic [3:0]  core_index;
        logic [31:0] service_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  core_slot;
        logic [7:0]  request_num;
        logic [47:0] event_time;
        logic [31:0] slice_length;
        logic [47:0] response_time;
        logic        late;
        logic        counted;
        logic [31:0] good_count;
        logic [31:0] bad_count;
        logic [31:0] drop_count;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT1,
        ST_DISP_CHK,
        ST_DIV,
        ST_DISP_RD,
        ST_DISP_WAIT,
        ST_MUL,
        ST_EMIT2
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic read_req;
        logic eval;
        logic emit1;
        logic disp_chk;
        logic div_start;
        logic disp_rd;
        logic disp_upd;
        logic mul;
        logic emit2;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic has_first;
        logic go_dispatch;
        logic can_dispatch;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

>>> hdl/qds_stream_if.sv
interface qds_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/qds_ctrl.sv
module qds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  qds_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output qds_pkg::t_ctrl o_ctrl
);
    import qds_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_READ;
            ST_READ:      n_state = ST_EVAL;
            ST_EVAL: begin
                if (i_stat.has_first)        n_state = ST_EMIT1;
                else                         n_state = ST_IDLE;
            end
            ST_EMIT1: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.go_dispatch) n_state = ST_DISP_CHK;
                    else                    n_state = ST_IDLE;
                end
            end
            ST_DISP_CHK:  n_state = i_stat.can_dispatch ? ST_DIV : ST_IDLE;
            ST_DIV:       if (i_stat.div_done) n_state = ST_DISP_RD;
            ST_DISP_RD:   n_state = ST_DISP_WAIT;
            ST_DISP_WAIT: n_state = ST_MUL;
            ST_MUL:       n_state = ST_EMIT2;
            ST_EMIT2:     if (!i_stat.out_busy) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctrl.load_in = i_in_valid;
            end
            ST_READ:      o_ctrl.read_req = 1'b1;
            ST_EVAL:      o_ctrl.eval = 1'b1;
            ST_EMIT1:     o_ctrl.emit1 = !i_stat.out_busy;
            ST_DISP_CHK:  o_ctrl.disp_chk = 1'b1;
            ST_DIV:       o_ctrl.div_start = 1'b1;
            ST_DISP_RD:   o_ctrl.disp_rd = 1'b1;
            ST_DISP_WAIT: o_ctrl.disp_upd = 1'b1;
            ST_MUL:       o_ctrl.mul = 1'b1;
            ST_EMIT2:     o_ctrl.emit2 = !i_stat.out_busy;
            default:      o_ctrl = '0;
        endcase
    end
endmodule

>>> hdl/qds_datapath.sv
module qds_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qds_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  qds_pkg::t_ctrl     i_ctrl,
    output qds_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qds_pkg::t_out_item o_out
);
    import qds_pkg::*;

    localparam int RW = $clog2(MAX_REQUESTS);
    localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int FW = RW + 1;

    // configuration registers
    logic        r_mode;
    logic [8:0]  r_qlimit;
    logic [4:0]  r_cores;
    logic [31:0] r_quantum, r_switch, r_tmo;
    logic [47:0] r_warmup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1; r_qlimit <= 9'd100; r_cores <= 5'd4;
            r_quantum <= 32'd13107; r_switch <= 32'd655;
            r_tmo <= 32'd327680; r_warmup <= 48'd131072000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_data[0];
                REG_QLIMIT:  r_qlimit  <= i_cfg_data[8:0];
                REG_CORES:   r_cores   <= i_cfg_data[4:0];
                REG_QUANTUM: r_quantum <= i_cfg_data[31:0];
                REG_SWITCH:  r_switch  <= i_cfg_data[31:0];
                REG_TIMEOUT: r_tmo     <= i_cfg_data[31:0];
                REG_WARMUP:  r_warmup  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cores in use, clamped to the core pool
    logic [6:0] w_ncores;
    assign w_ncores = ({2'b0, r_cores} < 7'(MAX_CORES)) ? {2'b0, r_cores} : 7'(MAX_CORES);

    // request tables and queue
    logic [RW-1:0] m_queue [MAX_REQUESTS];
    logic [47:0]   m_stamp [MAX_REQUESTS];
    logic [31:0]   m_work  [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] r_late;
    logic [MAX_CORES-1:0]    r_busy;
    logic [RW-1:0]           r_owner [MAX_CORES];
    logic [RW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [31:0]   r_good, r_bad, r_drop;

    t_in_item      r_in;
    logic [RW-1:0] r_req;       // request under work (first result)
    logic [47:0]   r_rd_stamp;
    logic [31:0]   r_rd_work;
    logic [RW-1:0] r_dreq;      // request being dispatched
    logic [CW-1:0] r_dcore;
    logic [31:0]   r_dwork;
    logic [31:0]   r_slice;
    logic [47:0]   r_cs;
    logic [47:0]   r_ftime;
    logic          r_go;
    logic          r_ign;
    t_out_item     r_first;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [RW-1:0] w_id;
    assign w_id = r_in.request_id[RW-1:0];

    // lowest free core in use
    logic          w_free_found;
    logic [CW-1:0] w_free_core;
    always_comb begin
        w_free_found = 1'b0;
        w_free_core  = '0;
        for (int c = MAX_CORES - 1; c >= 0; c--) begin
            if (!r_busy[c] && (7'(c) < w_ncores)) begin
                w_free_found = 1'b1;
                w_free_core  = CW'(c);
            end
        end
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // slice-done core checks
    logic          w_core_ok;
    logic [CW-1:0] w_core;
    assign w_core    = CW'(r_in.core_index);
    assign w_core_ok = ({3'b0, r_in.core_index} < w_ncores) &&
                       ({3'b0, r_in.core_index} < 7'(MAX_CORES)) && r_busy[w_core];

    // request whose tables are read for the first result
    logic [RW-1:0] w_rd_addr;
    assign w_rd_addr = (r_in.cmd == CMD_SLICE) ? r_owner[w_core] : w_id;

    // divider: load = (fill << 16) / ncores, restoring, one bit per cycle
    localparam int DW = FW + 16;
    localparam int NW = $clog2(DW + 1);
    logic [DW-1:0] r_quo;
    logic [6:0]    r_rem;
    logic [NW-1:0] r_dcnt;
    logic          r_div_busy, r_div_done;
    logic [7:0]    w_trial;
    assign w_trial = {r_rem, r_quo[DW-1]};

    logic [DW-1:0] w_load;
    assign w_load = (r_quo < DW'(65536)) ? DW'(65536) : r_quo;

    // queue store is full
    logic w_qfull;
    assign w_qfull = (r_fill == FW'(MAX_REQUESTS));

    // first result of an event and the table updates it implies
    t_out_item     w_first;
    logic          w_go;
    logic          w_admit;
    logic          w_requeue;
    always_comb begin
        w_first   = '0;
        w_go      = 1'b0;
        w_admit   = 1'b0;
        w_requeue = 1'b0;
        unique case (r_in.cmd)
            CMD_ARRIVAL: begin
                w_first.request_num = r_in.request_id;
                if (({{(16-FW){1'b0}}, r_fill} < {7'b0, r_qlimit}) && !w_qfull) begin
                    w_admit = 1'b1;
                    w_go    = 1'b1;
                    w_first.kind       = KIND_TIMEOUT;
                    w_first.event_time = r_in.now + {16'b0, r_tmo};
                end else begin
                    w_first.kind = KIND_DROPPED;
                end
            end
            CMD_SLICE: begin
                if (!r_ign) begin
                    w_go = 1'b1;
                    w_first.core_slot   = r_in.core_index;
                    w_first.request_num = 8'(r_req);
                    if (r_rd_work == 32'd0) begin
                        w_first.kind          = KIND_COMPLETED;
                        w_first.response_time = r_in.now - r_rd_stamp;
                        w_first.late          = r_late[r_req];
                        w_first.counted       = !r_late[r_req] && (r_in.now > r_warmup);
                    end else begin
                        w_first.kind = KIND_PREEMPTED;
                        w_requeue    = r_mode && !w_qfull;
                    end
                end
            end
            default: ;
        endcase
    end

    // queue write port
    logic          w_qwe;
    logic [RW-1:0] w_qaddr;
    logic [RW-1:0] w_qdata;
    assign w_qwe   = i_ctrl.eval && (w_admit || w_requeue);
    assign w_qaddr = RW'(r_head + RW'(r_fill));
    assign w_qdata = (r_in.cmd == CMD_SLICE) ? r_req : w_id;

    // granted slice and remainder
    logic [31:0] w_slice;
    logic [31:0] w_work_left;
    assign w_slice     = (r_mode && (r_quantum < r_dwork)) ? r_quantum : r_dwork;
    assign w_work_left = r_dwork - w_slice;

    // outgoing transactions
    t_out_item w_emit1;
    t_out_item w_emit2;
    always_comb begin
        w_emit1            = r_first;
        w_emit1.good_count = r_good;
        w_emit1.bad_count  = r_bad;
        w_emit1.drop_count = r_drop;
        w_emit1.last       = !(r_go && w_free_found && r_fill != '0);

        w_emit2              = '0;
        w_emit2.kind         = KIND_DISPATCH;
        w_emit2.core_slot    = 4'(r_dcore);
        w_emit2.request_num  = 8'(r_dreq);
        w_emit2.event_time   = r_ftime + r_cs;
        w_emit2.slice_length = r_slice;
        w_emit2.good_count   = r_good;
        w_emit2.bad_count    = r_bad;
        w_emit2.drop_count   = r_drop;
        w_emit2.last         = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0; r_fill <= '0; r_late <= '0; r_busy <= '0;
            r_good <= '0; r_bad <= '0; r_drop <= '0;
            r_out_valid <= 1'b0; r_div_busy <= 1'b0; r_div_done <= 1'b0;
            r_go <= 1'b0; r_ign <= 1'b0;
        end else begin
            if (i_ctrl.emit1 || i_ctrl.emit2) r_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;

            if (i_ctrl.load_in) r_in <= i_item;

            if (i_ctrl.read_req) begin
                r_req <= w_rd_addr;
                r_ign <= !w_core_ok;
            end

            // state updates of the event
            if (i_ctrl.eval) begin
                r_first <= w_first;
                r_go    <= w_go;
                if (w_admit || w_requeue) r_fill <= r_fill + FW'(1);
                unique case (r_in.cmd)
                    CMD_ARRIVAL: begin
                        r_late[w_id] <= 1'b0;
                        if (!w_admit) r_drop <= sat_inc(r_drop);
                    end
                    CMD_SLICE: begin
                        if (!r_ign) begin
                            r_busy[w_core] <= 1'b0;
                            if (w_first.late) r_bad <= sat_inc(r_bad);
                            else if (w_first.counted) r_good <= sat_inc(r_good);
                        end
                    end
                    CMD_TIMEOUT: r_late[w_id] <= 1'b1;
                    default: ;
                endcase
            end

            if (i_ctrl.emit1) r_out <= w_emit1;
            else if (i_ctrl.emit2) r_out <= w_emit2;

            if (i_ctrl.disp_chk) begin
                r_quo <= {r_fill, 16'b0};
                r_rem <= '0;
                r_dcnt <= '0;
                r_div_busy <= 1'b1;
                r_div_done <= 1'b0;
                r_dcore <= w_free_core;
            end

            if (i_ctrl.div_start && r_div_busy) begin
                if (w_trial >= {1'b0, w_ncores}) begin
                    r_rem <= 7'(w_trial - {1'b0, w_ncores});
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[6:0];
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + NW'(1);
                if (r_dcnt == NW'(DW - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end

            if (i_ctrl.disp_rd) begin
                r_div_done <= 1'b0;
                r_head <= RW'(r_head + RW'(1));
                r_fill <= r_fill - FW'(1);
                r_busy[r_dcore]  <= 1'b1;
                r_owner[r_dcore] <= r_dreq;
            end

            if (i_ctrl.disp_upd) begin
                r_slice <= w_slice;
                r_cs    <= {16'b0, r_switch};
            end

            // overhead scale, one registered product
            if (i_ctrl.mul) begin
                if (r_mode) r_cs <= 48'((64'(r_switch) * (64'(w_load) + 64'd65536)) >> 16);
                r_ftime <= r_in.now + {16'b0, r_slice};
            end
        end
    end

    // request tables: registered reads, one write port each
    always_ff @(posedge i_clk) begin
        if (i_ctrl.read_req) begin
            r_rd_stamp <= m_stamp[w_rd_addr];
            r_rd_work  <= m_work[w_rd_addr];
        end
        if (i_ctrl.eval && r_in.cmd == CMD_ARRIVAL) m_stamp[w_id] <= r_in.now;
        if (i_ctrl.eval && r_in.cmd == CMD_ARRIVAL) m_work[w_id] <= r_in.service_time;
        else if (i_ctrl.disp_upd) m_work[r_dreq] <= w_work_left;
        if (w_qwe) m_queue[w_qaddr] <= w_qdata;
        if (i_ctrl.disp_chk) r_dreq <= m_queue[r_head];
        if (i_ctrl.disp_rd) r_dwork <= m_work[r_dreq];
    end

    assign o_stat.has_first    = (r_in.cmd == CMD_ARRIVAL) ||
                                 (r_in.cmd == CMD_SLICE && !r_ign);
    assign o_stat.go_dispatch  = r_go;
    assign o_stat.can_dispatch = w_free_found && (r_fill != '0);
    assign o_stat.div_done     = r_div_done;
    assign o_stat.out_busy     = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

>>> hdl/quantum_dispatch_scheduler_top.sv
// Channel  Dir  Payload                                         Handshake
// in_if    in   cmd, now, request_id, core_index, service_time  valid/ready
// out_if   out  kind .. last (up to two results per event)      valid/ready
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data                 write enable
//
// One event at a time: an event with a dispatch runs the 25-bit divide of the
// queue fill by the core count, one bit a cycle, before its second result; an
// event with a single result or with none returns to idle without the divide.
// Reset is synchronous and active low; all tables need no clearing pass.
// A stalled output holds the controller in its emit state.
module quantum_dispatch_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qds_stream_if.sink   in_if,
    qds_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    import qds_pkg::*;

    t_ctrl     w_ctrl;
    t_stat     w_stat;
    t_out_item w_out;

    qds_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (in_if.valid),
        .i_stat     (w_stat),
        .o_in_ready (in_if.ready),
        .o_ctrl     (w_ctrl)
    );

    qds_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_item      (t_in_item'(in_if.data)),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .o_out       (w_out)
    );

    assign out_if.data = w_out;
endmodule

>>> hdl/qds_checker.sv
module qds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind
);
    // one transaction at a time on the input
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("input taken twice in a row");
    // a held result keeps its valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid) else $error("result dropped");
    // a held result keeps its kind
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_kind)) else $error("result changed");
    // kinds in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_kind <= 3'd4) else $error("bad kind");
endmodule

bind quantum_dispatch_scheduler_top qds_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid (in_if.valid), .i_in_ready (in_if.ready),
    .i_out_valid (out_if.valid), .i_out_ready (out_if.ready),
    .i_out_kind (out_if.data[241:239])
);

>>> bench/tb_quantum_dispatch_scheduler_top.sv
module tb_quantum_dispatch_scheduler_top;
    import qds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_REQ   = 256;
    localparam int N_CORES = 16;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [47:0] i_cfg_data;

    qds_stream_if #(.W($bits(t_in_item)))  in_if ();
    qds_stream_if #(.W($bits(t_out_item))) out_if ();

    quantum_dispatch_scheduler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_if      (in_if.sink),
        .out_if     (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // shadow of the scheduler configuration
    logic        m_mode;
    logic [8:0]  m_qlimit;
    logic [4:0]  m_cores;
    logic [31:0] m_quantum;
    logic [31:0] m_switch;
    logic [31:0] m_tmo;
    logic [47:0] m_warmup;

    // shadow of the scheduler state
    logic [7:0]  s_queue [N_REQ];
    logic [7:0]  s_head;
    logic [8:0]  s_fill;
    logic [47:0] s_arrival [N_REQ];
    logic [31:0] s_work [N_REQ];
    logic        s_late [N_REQ];
    logic        s_busy [N_CORES];
    logic [7:0]  s_owner [N_CORES];
    logic [31:0] s_good, s_bad, s_drop;

    t_in_item  pending_events[$];
    t_out_item expected_results[$];

    int  n_errors = 0;
    int  n_events = 0;
    int  n_results = 0;
    int  n_dispatch = 0;
    int  n_complete = 0;
    bit  quiet = 1'b0;
    bit  in_busy_phase = 1'b0;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int active_cores();
        return (m_cores < N_CORES) ? int'(m_cores) : N_CORES;
    endfunction

    function automatic t_out_item blank_result(t_kind k);
        t_out_item r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // pick the lowest free core for the queue head, if any
    function automatic bit dispatch_head(logic [47:0] now, output t_out_item r);
        int n;
        int c;
        logic [63:0] load;
        logic [7:0]  req;
        logic [31:0] slice;
        logic [63:0] ovh;
        n = active_cores();
        c = 0;
        while (c < n && s_busy[c]) c++;
        if (c >= n || s_fill == 0) return 1'b0;
        load = (64'(s_fill) << 16) / n;
        if (load < 64'h10000) load = 64'h10000;
        req = s_queue[s_head];
        s_head = s_head + 8'd1;
        s_fill = s_fill - 9'd1;
        s_busy[c] = 1'b1;
        s_owner[c] = req;
        if (!m_mode) begin
            slice = s_work[req];
            s_work[req] = '0;
            ovh = 64'(m_switch);
        end else begin
            slice = (m_quantum < s_work[req]) ? m_quantum : s_work[req];
            s_work[req] = s_work[req] - slice;
            ovh = (64'(m_switch) * (64'h10000 + load)) >> 16;
        end
        r = blank_result(KIND_DISPATCH);
        r.core_slot = 4'(c);
        r.request_num = req;
        r.event_time = 48'(64'(now) + 64'(slice) + ovh);
        r.slice_length = slice;
        return 1'b1;
    endfunction

    function automatic bit queue_push(logic [7:0] id);
        if (s_fill >= N_REQ) return 1'b0;
        s_queue[8'(s_head + s_fill[7:0])] = id;
        s_fill = s_fill + 9'd1;
        return 1'b1;
    endfunction

    // work out the results of one event and queue them
    task automatic predict_event(t_in_item ev);
        t_out_item res[$];
        t_out_item r;
        t_out_item d;
        logic [7:0] req;
        int cidx;
        res = {};
        if (ev.cmd == CMD_ARRIVAL) begin
            s_arrival[ev.request_id] = ev.now;
            s_work[ev.request_id] = ev.service_time;
            s_late[ev.request_id] = 1'b0;
            if (s_fill < m_qlimit && queue_push(ev.request_id)) begin
                r = blank_result(KIND_TIMEOUT);
                r.request_num = ev.request_id;
                r.event_time = ev.now + 48'(m_tmo);
                res.insert(res.size(), r);
                if (dispatch_head(ev.now, d)) res.insert(res.size(), d);
            end else begin
                s_drop = sat_inc(s_drop);
                r = blank_result(KIND_DROPPED);
                r.request_num = ev.request_id;
                res.insert(res.size(), r);
            end
        end else if (ev.cmd == CMD_SLICE) begin
            cidx = int'(ev.core_index);
            if (cidx < active_cores() && s_busy[cidx]) begin
                req = s_owner[cidx];
                s_busy[cidx] = 1'b0;
                if (s_work[req] == 0) begin
                    r = blank_result(KIND_COMPLETED);
                    if (!s_late[req]) begin
                        if (ev.now > m_warmup) begin
                            s_good = sat_inc(s_good);
                            r.counted = 1'b1;
                        end
                    end else begin
                        s_bad = sat_inc(s_bad);
                        r.late = 1'b1;
                    end
                    r.response_time = ev.now - s_arrival[req];
                end else begin
                    if (m_mode) void'(queue_push(req));
                    r = blank_result(KIND_PREEMPTED);
                end
                r.core_slot = ev.core_index;
                r.request_num = req;
                res.insert(res.size(), r);
                if (dispatch_head(ev.now, d)) res.insert(res.size(), d);
            end
        end else if (ev.cmd == CMD_TIMEOUT) begin
            s_late[ev.request_id] = 1'b1;
        end
        foreach (res[i]) begin
            res[i].good_count = s_good;
            res[i].bad_count = s_bad;
            res[i].drop_count = s_drop;
            res[i].last = (i == res.size() - 1);
            expected_results.insert(expected_results.size(), res[i]);
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_events.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
                in_if.valid <= 1'b1;
                in_if.data <= pending_events.pop_front();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // prediction on each accepted event
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_event(t_in_item'(in_if.data));
            n_events++;
        end
    end

    // output backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= quiet || ($urandom_range(99) >= 14);
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = t_out_item'(out_if.data);
            n_results++;
            if (got.kind == KIND_DISPATCH) n_dispatch++;
            if (got.kind == KIND_COMPLETED) n_complete++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch:\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [31:0] rand_svc();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return 32'($urandom_range(200000));
        endcase
    endfunction

    task automatic add_event(t_cmd c, logic [47:0] now, logic [7:0] id,
                             logic [3:0] core, logic [31:0] svc);
        t_in_item ev;
        ev.cmd = c;
        ev.now = now;
        ev.request_id = id;
        ev.core_index = core;
        ev.service_time = svc;
        pending_events.insert(pending_events.size(), ev);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:    m_mode = val[0];
            REG_QLIMIT:  m_qlimit = val[8:0];
            REG_CORES:   m_cores = val[4:0];
            REG_QUANTUM: m_quantum = val[31:0];
            REG_SWITCH:  m_switch = val[31:0];
            REG_TIMEOUT: m_tmo = val[31:0];
            default:     m_warmup = val;
        endcase
    endtask

    // wait for every queued event and result, then let the block settle
    task automatic drain();
        while (pending_events.size() > 0 || in_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // random traffic: mostly arrivals and slice-done events, most on cores 0 to 5
    task automatic random_phase(int count);
        logic [47:0] t;
        int c;
        t = rand48() >> 8;
        for (int i = 0; i < count; i++) begin
            t = t + 48'($urandom_range(300000));
            c = $urandom_range(99);
            if (c < 45)
                add_event(CMD_ARRIVAL, t, 8'($urandom), 4'($urandom), rand_svc());
            else if (c < 85)
                add_event(CMD_SLICE, t, 8'($urandom), 4'($urandom_range(5)), $urandom);
            else if (c < 93)
                add_event(CMD_SLICE, t, 8'($urandom), 4'($urandom), $urandom);
            else if (c < 98)
                add_event(CMD_TIMEOUT, t, 8'($urandom), 4'($urandom), $urandom);
            else
                add_event(CMD_NONE, rand48(), 8'($urandom), 4'($urandom), $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MODE;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        m_mode = 1'b1;
        m_qlimit = 9'd100;
        m_cores = 5'd4;
        m_quantum = 32'd13107;
        m_switch = 32'd655;
        m_tmo = 32'd327680;
        m_warmup = 48'd131072000;
        s_head = '0;
        s_fill = '0;
        s_good = '0;
        s_bad = '0;
        s_drop = '0;
        for (int i = 0; i < N_REQ; i++) begin
            s_queue[i] = '0;
            s_arrival[i] = '0;
            s_work[i] = '0;
            s_late[i] = 1'b0;
        end
        for (int i = 0; i < N_CORES; i++) begin
            s_busy[i] = 1'b0;
            s_owner[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes of fields, all commands
        add_event(CMD_SLICE, 48'd5, 8'd0, 4'd0, 32'd0);
        add_event(CMD_ARRIVAL, 48'd0, 8'd0, 4'd0, 32'd0);
        add_event(CMD_ARRIVAL, MASK48, 8'd255, 4'd15, 32'hFFFF_FFFF);
        add_event(CMD_ARRIVAL, 48'd100, 8'd7, 4'd0, 32'd20000);
        add_event(CMD_TIMEOUT, 48'd200, 8'd7, 4'd15, 32'hFFFF_FFFF);
        add_event(CMD_ARRIVAL, 48'd300, 8'd9, 4'd0, 32'd50000);
        add_event(CMD_ARRIVAL, 48'd400, 8'd10, 4'd0, 32'd1000);
        add_event(CMD_SLICE, 48'd500, 8'd0, 4'd0, 32'd0);
        add_event(CMD_SLICE, 48'd600, 8'd0, 4'd2, 32'd0);
        add_event(CMD_SLICE, 48'd700, 8'd0, 4'd3, 32'd0);
        add_event(CMD_SLICE, 48'hFFFF_FFFF_0000, 8'd0, 4'd1, 32'd0);
        add_event(CMD_SLICE, 48'd800, 8'd0, 4'd15, 32'd0);
        add_event(CMD_SLICE, 48'd900, 8'd0, 4'd0, 32'd0);
        add_event(CMD_NONE, MASK48, 8'd255, 4'd15, 32'hFFFF_FFFF);
        add_event(CMD_SLICE, 48'd1000, 8'd0, 4'd2, 32'd0);
        add_event(CMD_SLICE, 48'd1100, 8'd0, 4'd3, 32'd0);
        drain();

        // FIFO mode, re-arrival while running leaves a remainder
        write_reg(REG_MODE, 48'd0);
        write_reg(REG_CORES, 48'd1);
        write_reg(REG_WARMUP, 48'd0);
        add_event(CMD_ARRIVAL, 48'd10, 8'd3, 4'd0, 32'd500);
        add_event(CMD_ARRIVAL, 48'd20, 8'd3, 4'd0, 32'd700);
        add_event(CMD_SLICE, 48'd30, 8'd0, 4'd0, 32'd0);
        add_event(CMD_SLICE, 48'd40, 8'd0, 4'd0, 32'd0);
        add_event(CMD_SLICE, 48'd50, 8'd0, 4'd0, 32'd0);
        drain();

        // queue limit zero drops everything; core count zero never dispatches
        write_reg(REG_QLIMIT, 48'd0);
        add_event(CMD_ARRIVAL, 48'd60, 8'd1, 4'd0, 32'd5);
        drain();
        write_reg(REG_QLIMIT, 48'd256);
        write_reg(REG_CORES, 48'd0);
        add_event(CMD_ARRIVAL, 48'd70, 8'd2, 4'd0, 32'd5);
        add_event(CMD_SLICE, 48'd80, 8'd0, 4'd0, 32'd0);
        drain();

        // random phases over several settings, extremes included
        quiet = 1'b1;
        write_reg(REG_CORES, 48'd16);
        write_reg(REG_MODE, 48'd1);
        write_reg(REG_QUANTUM, 48'hFFFF_FFFF);
        write_reg(REG_SWITCH, 48'hFFFF_FFFF);
        write_reg(REG_TIMEOUT, 48'hFFFF_FFFF);
        write_reg(REG_WARMUP, MASK48);
        random_phase(120);
        drain();
        quiet = 1'b0;

        write_reg(REG_CORES, 48'd3);
        write_reg(REG_QUANTUM, 48'd0);
        write_reg(REG_SWITCH, 48'd0);
        write_reg(REG_TIMEOUT, 48'd0);
        write_reg(REG_WARMUP, 48'd0);
        write_reg(REG_QLIMIT, 48'd6);
        random_phase(200);
        drain();

        write_reg(REG_MODE, 48'd0);
        write_reg(REG_CORES, 48'd5);
        write_reg(REG_SWITCH, 48'd655);
        write_reg(REG_TIMEOUT, 48'd327680);
        write_reg(REG_WARMUP, 48'd131072000);
        write_reg(REG_QLIMIT, 48'd256);
        random_phase(220);
        drain();

        write_reg(REG_MODE, 48'd1);
        write_reg(REG_CORES, 48'd2);
        write_reg(REG_QUANTUM, 48'd13107);
        write_reg(REG_QLIMIT, 48'd40);
        random_phase(240);
        drain();

        write_reg(REG_CORES, 48'd31);
        write_reg(REG_QUANTUM, 48'd30000);
        write_reg(REG_SWITCH, {16'd0, $urandom});
        write_reg(REG_WARMUP, rand48());
        write_reg(REG_QLIMIT, 48'd511);
        random_phase(220);
        drain();

        $display("Ran %0d events giving %0d results (%0d dispatches, %0d completions)",
                 n_events, n_results, n_dispatch, n_complete);
        $display("Covered FIFO and round-robin modes, drops, timeouts, %0d mismatches",
                 n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> quantum_dispatch_scheduler_top.f
hdl/qds_pkg.sv
hdl/qds_stream_if.sv
hdl/qds_ctrl.sv
hdl/qds_datapath.sv
hdl/quantum_dispatch_scheduler_top.sv
hdl/qds_checker.sv
bench/tb_quantum_dispatch_scheduler_top.sv
